FILE: rtl/gbt_pkg.sv
`timescale 1ns / 1ps
package gbt_pkg;

  localparam int NUM_HYP   = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = NUM_HYP * NUM_HYP;
  localparam int VAL_W     = 32;
  localparam int FRAC      = 30;
  localparam int ALPHA_W   = 31;
  localparam int CNT_W     = 4;
  localparam int DEN_W     = FRAC + 1;
  localparam int REM_W     = FRAC;

  localparam logic [VAL_W-1:0] VMAX    = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_PVAL   = 2'd2;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_NHYP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_SMUL,
    ST_SCMP,
    ST_RRD1,
    ST_RRD2,
    ST_RMUL1,
    ST_RMUL2,
    ST_RWGT,
    ST_ERD1,
    ST_ERD2,
    ST_EMUL,
    ST_ENUM,
    ST_EDIV,
    ST_ZROW,
    ST_DONE
  } state_t;

  function automatic logic [VAL_W-1:0] fx_sat(input logic [2*VAL_W-1:0] p);
    logic [VAL_W-1:0] r;
    if (p[2*VAL_W-1:FRAC+VAL_W] != '0) begin
      r = VMAX;
    end else begin
      r = p[FRAC+VAL_W-1:FRAC];
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? VMAX : s[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/gbt_div.sv
`timescale 1ns / 1ps
module gbt_div import gbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VAL_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [VAL_W-1:0]     quot
);

  logic             run;
  logic [4:0]       cnt;
  logic [REM_W-1:0] rem;
  logic [VAL_W-1:0] src;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W-1:0] rem2;
  logic             qbit;

  assign rem2 = {rem, src[VAL_W-1]};
  assign qbit = (rem2 >= dreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 5'd31);
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= num[VAL_W-1:2];
        src  <= {num[1:0], {(VAL_W-2){1'b0}}};
        dreg <= den;
        quot <= '0;
      end else if (run) begin
        rem  <= qbit ? REM_W'(rem2 - dreg) : rem2[REM_W-1:0];
        quot <= {quot[VAL_W-2:0], qbit};
        src  <= {src[VAL_W-2:0], 1'b0};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/graphical_bonferroni_test_top.sv
`timescale 1ns / 1ps
// Load items (weight, edge, p-value without last) are accepted only while busy is low.
// A p-value with last_of_vector starts a test: the graph is copied, then a search pass
// tests each hypothesis in turn; a rejection round updates the weight of every other row
// and each of its edges, using the 32-step divider where an edge needs it, and then clears
// the rejected row. done then pulses for one cycle; busy holds from the transfer until then.
// Reset clears weights, edge valid bits, mask and the control registers; results cannot stall.
module graphical_bonferroni_test_top import gbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [IDX_W-1:0]   row_index,
  input  logic [IDX_W-1:0]   col_index,
  input  logic [VAL_W-1:0]   value,
  input  logic               last_of_vector,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [ALPHA_W-1:0] cfg_data,
  output logic               done,
  output logic [7:0]         rejected_mask
);

  state_t state, state_next;

  logic [ALPHA_W-1:0] alpha_level;
  logic [CNT_W-1:0]   hyp_in_use;
  logic [CNT_W-1:0]   n_eff;

  logic [VAL_W-1:0]   base_w [NUM_HYP];
  logic [VAL_W-1:0]   pval   [NUM_HYP];
  logic [VAL_W-1:0]   ww     [NUM_HYP];
  logic [VAL_W-1:0]   base_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] base_vld;
  logic [VAL_W-1:0]   base_rdata;
  logic               base_rvld;
  logic [VAL_W-1:0]   work_mem [MEM_DEPTH];
  logic [VAL_W-1:0]   work_rdata;

  logic [6:0]         cnt;
  logic [IDX_W-1:0]   r, h, e;
  logic [NUM_HYP-1:0] mask;
  logic [CNT_W-1:0]   rej_count;
  logic [VAL_W-1:0]   hr, rh, he, wr;
  logic [DEN_W-1:0]   den;
  logic               den_ok;
  logic [2*VAL_W-1:0] prod_q;

  logic               accept;
  logic               r_last, h_last, e_last;
  logic               pass, found;
  logic [VAL_W-1:0]   mul_a, mul_b;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;
  logic [VAL_W-1:0]   wr_data;
  logic [IDX_W-1:0]   ww_idx;
  logic [VAL_W-1:0]   ww_rd;
  logic [VAL_W-1:0]   num;
  logic               num_zero, num_sat;
  logic               div_start, div_done;
  logic [VAL_W-1:0]   div_quot;
  logic               row_end;
  logic [VAL_W-1:0]   pf;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign n_eff  = (hyp_in_use == '0) ? CNT_W'(1) :
                  (hyp_in_use > CNT_W'(NUM_HYP)) ? CNT_W'(NUM_HYP) : hyp_in_use;
  assign r_last = ({1'b0, r} == n_eff - CNT_W'(1));
  assign h_last = ({1'b0, h} == n_eff - CNT_W'(1));
  assign e_last = ({1'b0, e} == n_eff - CNT_W'(1));

  assign ww_idx = (state == ST_RWGT) ? h : r;
  assign ww_rd  = ww[ww_idx];
  assign pass   = ({2'b00, pval[r], {FRAC{1'b0}}} <= prod_q) ? 1'b1 : 1'b0;
  assign found  = !mask[r] && pass;
  assign pf     = fx_sat(prod_q);
  assign num      = sat_add(he, pf);
  assign num_zero = (h == e) || (e == r) || !den_ok;
  assign num_sat  = ({1'b0, num} >= {den, 2'b00});
  assign row_end  = e_last;

  assign rejected_mask = mask[7:0];
  assign done          = (state == ST_DONE);

  gbt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && mode == MODE_PVAL && last_of_vector) state_next = ST_COPY;
      ST_COPY:  if (cnt == 7'(MEM_DEPTH)) state_next = ST_SMUL;
      ST_SMUL:  state_next = ST_SCMP;
      ST_SCMP: begin
        if (found) begin
          state_next = (rej_count + CNT_W'(1) == n_eff) ? ST_DONE : ST_RRD1;
        end else begin
          state_next = r_last ? ST_DONE : ST_SMUL;
        end
      end
      ST_RRD1: begin
        if (h == r) begin
          state_next = h_last ? ST_ZROW : ST_RRD1;
        end else begin
          state_next = ST_RRD2;
        end
      end
      ST_RRD2:  state_next = ST_RMUL1;
      ST_RMUL1: state_next = ST_RMUL2;
      ST_RMUL2: state_next = ST_RWGT;
      ST_RWGT:  state_next = ST_ERD1;
      ST_ERD1:  state_next = ST_ERD2;
      ST_ERD2:  state_next = ST_EMUL;
      ST_EMUL:  state_next = ST_ENUM;
      ST_ENUM: begin
        if (num_zero || num_sat) begin
          state_next = !row_end ? ST_ERD1 : (h_last ? ST_ZROW : ST_RRD1);
        end else begin
          state_next = ST_EDIV;
        end
      end
      ST_EDIV: begin
        if (div_done) begin
          state_next = !row_end ? ST_ERD1 : (h_last ? ST_ZROW : ST_RRD1);
        end
      end
      ST_ZROW:  if (e_last) state_next = ST_SMUL;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    unique case (state)
      ST_COPY: begin
        rd_addr = cnt[ADDR_W-1:0];
        wr_en   = (cnt != '0);
        wr_addr = ADDR_W'(cnt - 7'd1);
        wr_data = base_rvld ? base_rdata : '0;
      end
      ST_SMUL: begin
        mul_a = ww_rd;
        mul_b = VAL_W'(alpha_level);
      end
      ST_RRD1:  rd_addr = {h, r};
      ST_RRD2:  rd_addr = {r, h};
      ST_RMUL1: begin
        mul_a = hr;
        mul_b = work_rdata;
      end
      ST_RMUL2: begin
        mul_a = wr;
        mul_b = rh;
      end
      ST_ERD1:  rd_addr = {h, e};
      ST_ERD2:  rd_addr = {r, e};
      ST_EMUL: begin
        mul_a = hr;
        mul_b = work_rdata;
      end
      ST_ENUM: begin
        wr_addr = {h, e};
        if (num_zero) begin
          wr_en = 1'b1;
        end else if (num_sat) begin
          wr_en   = 1'b1;
          wr_data = VMAX;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_EDIV: begin
        wr_addr = {h, e};
        wr_en   = div_done;
        wr_data = div_quot;
      end
      ST_ZROW: begin
        wr_en   = 1'b1;
        wr_addr = {r, e};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      work_mem[wr_addr] <= wr_data;
    end
    work_rdata <= work_mem[rd_addr];
    if (accept && mode == MODE_EDGE) begin
      base_mem[{row_index, col_index}] <= value;
    end
    base_rdata <= base_mem[rd_addr];
    prod_q     <= {{VAL_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      alpha_level <= ALPHA_W'(26843546);
      hyp_in_use  <= CNT_W'(NUM_HYP);
      base_vld    <= '0;
      base_rvld   <= 1'b0;
      mask        <= '0;
      rej_count   <= '0;
      cnt         <= '0;
      r           <= '0;
      h           <= '0;
      e           <= '0;
      for (int i = 0; i < NUM_HYP; i++) begin
        base_w[i] <= '0;
      end
    end else begin
      state     <= state_next;
      base_rvld <= base_vld[rd_addr];
      if (cfg_write) begin
        if (cfg_index == CFG_ALPHA) begin
          alpha_level <= cfg_data;
        end else begin
          hyp_in_use <= cfg_data[CNT_W-1:0];
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_WEIGHT: base_w[row_index] <= value;
              MODE_EDGE:   base_vld[{row_index, col_index}] <= 1'b1;
              MODE_PVAL: begin
                pval[row_index] <= value;
                if (last_of_vector) begin
                  mask      <= '0;
                  rej_count <= '0;
                  cnt       <= '0;
                  r         <= '0;
                  for (int i = 0; i < NUM_HYP; i++) begin
                    ww[i] <= base_w[i];
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_COPY: cnt <= cnt + 7'd1;
        ST_SCMP: begin
          if (found) begin
            mask[r]   <= 1'b1;
            rej_count <= rej_count + CNT_W'(1);
            wr        <= ww_rd;
            h         <= '0;
          end else if (!r_last) begin
            r <= r + IDX_W'(1);
          end
        end
        ST_RRD1: begin
          e <= '0;
          if (h == r && !h_last) begin
            h <= h + IDX_W'(1);
          end
        end
        ST_RRD2:  hr <= work_rdata;
        ST_RMUL1: rh <= work_rdata;
        ST_RMUL2: begin
          den_ok <= (pf < ONE_VAL);
          den    <= DEN_W'(ONE_VAL) - pf[DEN_W-1:0];
        end
        ST_RWGT: begin
          ww[ww_idx] <= sat_add(ww_rd, pf);
          e          <= '0;
        end
        ST_ERD2: he <= work_rdata;
        ST_ENUM: begin
          if (num_zero || num_sat) begin
            if (!row_end) begin
              e <= e + IDX_W'(1);
            end else begin
              e <= '0;
              if (!h_last) h <= h + IDX_W'(1);
            end
          end
        end
        ST_EDIV: begin
          if (div_done) begin
            if (!row_end) begin
              e <= e + IDX_W'(1);
            end else begin
              e <= '0;
              if (!h_last) h <= h + IDX_W'(1);
            end
          end
        end
        ST_ZROW: begin
          if (e_last) begin
            ww[r] <= '0;
            r     <= '0;
            e     <= '0;
          end else begin
            e <= e + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
